### sv/assert_macros.svh
// Assertion helpers for the RTL files of the event count table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
        else $error("assertion failed: invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication violated");

// A consequence that must hold in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

### sv/pscet_pkg.sv
package pscet_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 4;
    localparam int SLOTS_DEF = 16;

    // Configuration port: two registers at byte addresses 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam logic REG_INVALID_ID = 1'b0;
    localparam logic REG_NOTIFY_EN  = 1'b1;

    localparam logic [DATA_W-1:0] INVALID_ID_RST = '1;
    localparam logic              NOTIFY_EN_RST  = 1'b1;

    // Write strobes from the sequencer to the table storage.
    typedef struct packed {
        logic id_we;
        logic data_we;
        logic zero_we;
    } tbl_ctl_t;

    // Saturating increment of an event count.
    function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = (v == '1) ? v : v + DATA_W'(1);
        return r;
    endfunction

endpackage

### sv/pscet_table.sv
module pscet_table
    import pscet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tbl_ctl_t                 ctl,
    input  logic [$clog2(SLOTS)-1:0] rd_addr,
    input  logic [$clog2(SLOTS)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_id,
    input  logic [DATA_W-1:0]        wr_count,
    input  logic [DATA_W-1:0]        wr_start,
    input  logic [DATA_W-1:0]        wr_end,
    output logic [DATA_W-1:0]        rd_id,
    output logic [DATA_W-1:0]        rd_count,
    output logic [DATA_W-1:0]        rd_start,
    output logic [DATA_W-1:0]        rd_end,
    output logic [DATA_W-1:0]        zero_count,
    output logic [DATA_W-1:0]        zero_start,
    output logic [DATA_W-1:0]        zero_end
);

    localparam int REC_W = 3 * DATA_W;

    // Slots 1 upwards live in memories; only slots below the fill count are
    // ever used, and those have always been written first.
    logic [DATA_W-1:0] id_mem   [SLOTS];
    logic [REC_W-1:0]  data_mem [SLOTS];

    logic [DATA_W-1:0] id_rd_reg;
    logic [REC_W-1:0]  data_rd_reg;

    // The reserved slot keeps its own registers, cleared by reset.
    logic [DATA_W-1:0] zero_count_reg;
    logic [DATA_W-1:0] zero_start_reg;
    logic [DATA_W-1:0] zero_end_reg;

    // Identifier memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.id_we)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        id_rd_reg <= id_mem[rd_addr];
    end

    // Count and time memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.data_we)
        begin
            data_mem[wr_addr] <= {wr_count, wr_start, wr_end};
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    // Reserved slot registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_count_reg <= '0;
            zero_start_reg <= '0;
            zero_end_reg   <= '0;
        end
        else if (ctl.zero_we)
        begin
            zero_count_reg <= wr_count;
            zero_start_reg <= wr_start;
            zero_end_reg   <= wr_end;
        end
    end

    assign rd_id      = id_rd_reg;
    assign rd_count   = data_rd_reg[REC_W-1 -: DATA_W];
    assign rd_start   = data_rd_reg[2*DATA_W-1 -: DATA_W];
    assign rd_end     = data_rd_reg[DATA_W-1:0];
    assign zero_count = zero_count_reg;
    assign zero_start = zero_start_reg;
    assign zero_end   = zero_end_reg;

endmodule

### sv/per_source_event_count_table.sv
// Channel   Direction  Handshake            Beat contents
// events    in         ev_valid / ev_stall  source_id, now_seconds
// results   out        res_valid/res_stall  slot, event_count, first_seen, last_seen,
//                                           new_entry, notify, overflowed
// config    in         APB (psel..pready)   invalid_id at 0x0, notify_enable at 0x4
//
// An event is captured while idle, checked against the invalid id, then compared with
// the occupied slots until a hit or a miss (none for the reserved slot, up to SLOTS-2):
// one shared 32-bit comparator checks one stored id per cycle against the event.
// The result is written into an output register once the last compare is done.
// Reset sets the fill count to one and clears the reserved slot; no clearing pass is needed.
// A stalled result is held; the next event is searched meanwhile and waits in its
// final step until the result register is free.
module per_source_event_count_table
    import pscet_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // Event channel
    input  logic                  ev_valid,
    output logic                  ev_stall,
    input  logic [DATA_W-1:0]     source_id,
    input  logic [DATA_W-1:0]     now_seconds,
    // Result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [SLOT_W-1:0]     slot,
    output logic [DATA_W-1:0]     event_count,
    output logic [DATA_W-1:0]     first_seen,
    output logic [DATA_W-1:0]     last_seen,
    output logic                  new_entry,
    output logic                  notify,
    output logic                  overflowed
);

`include "assert_macros.svh"

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int FILL_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_SEARCH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [DATA_W-1:0]  id_reg, now_reg;
    logic [DATA_W-1:0]  invalid_id_reg;
    logic               notify_en_reg;

    logic               res_valid_reg, res_valid_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [DATA_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0]  first_reg, first_next;
    logic [DATA_W-1:0]  last_reg, last_next;
    logic               new_reg, new_next;
    logic               notify_reg, notify_next;
    logic               ovf_reg, ovf_next;

    tbl_ctl_t           tbl_ctl;
    logic [IDX_W-1:0]   wr_addr;
    logic [DATA_W-1:0]  rd_id, rd_count, rd_start, rd_end;
    logic [DATA_W-1:0]  zero_count, zero_start, zero_end;

    logic               cfg_wr;
    logic [DATA_W-1:0]  cmp_b;
    logic               match;
    logic               full;
    logic               single;
    logic               to_zero;
    logic [FILL_W-1:0]  ptr_inc;
    logic               last_cmp;
    logic               res_free;
    logic               do_zero, do_hit, do_miss, finish;
    logic [IDX_W-1:0]   fin_idx;
    logic [IDX_W+SLOT_W-1:0] fin_idx_ext;
    logic [DATA_W-1:0]  inc_src, inc_res;
    logic [DATA_W-1:0]  wr_count, wr_start;

    // Configuration registers; the byte-lane bits of the address are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invalid_id_reg <= INVALID_ID_RST;
            notify_en_reg  <= NOTIFY_EN_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_INVALID_ID: invalid_id_reg <= pwdata;
                REG_NOTIFY_EN:  notify_en_reg  <= pwdata[0];
                default:        invalid_id_reg <= invalid_id_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_INVALID_ID: prdata = invalid_id_reg;
            REG_NOTIFY_EN:  prdata = {{(DATA_W-1){1'b0}}, notify_en_reg};
            default:        prdata = '0;
        endcase
    end

    // Shared comparator: the invalid id while checking, a stored id while searching.
    assign cmp_b = (state_reg == ST_CHECK) ? invalid_id_reg : rd_id;
    assign match = (id_reg == cmp_b);

    assign full     = (fill_reg >= FILL_W'(SLOTS));
    assign single   = (fill_reg == FILL_W'(1));
    assign to_zero  = full || match;
    assign ptr_inc  = FILL_W'(ptr_reg) + FILL_W'(1);
    assign last_cmp = (ptr_inc == fill_reg);
    assign res_free = !res_valid_reg || !res_stall;

    // Which update finishes this cycle.
    assign do_zero = (state_reg == ST_CHECK) && to_zero && res_free;
    assign do_hit  = (state_reg == ST_SEARCH) && match && res_free;
    assign do_miss = res_free &&
                     (((state_reg == ST_CHECK) && !to_zero && single) ||
                      ((state_reg == ST_SEARCH) && !match && last_cmp));
    assign finish  = do_zero || do_hit || do_miss;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ptr_next = IDX_W'(1);
                if (ev_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ptr_next = IDX_W'(1);
                if (to_zero || single)
                begin
                    if (res_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (match || last_cmp)
                begin
                    if (res_free)
                    begin
                        state_next = ST_IDLE;
                        ptr_next   = IDX_W'(1);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ptr_next   = IDX_W'(1);
            end
        endcase
        if (do_miss)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    assign ev_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= FILL_W'(1);
            ptr_reg   <= IDX_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Event beat capture.
    always_ff @(posedge clk)
    begin
        if (ev_valid && !ev_stall)
        begin
            id_reg  <= source_id;
            now_reg <= now_seconds;
        end
    end

    // Update values for the slot being finished.
    assign inc_src = do_zero ? zero_count : rd_count;
    assign inc_res = sat_inc(inc_src);

    always_comb
    begin
        if (do_zero)
        begin
            wr_count = inc_res;
            wr_start = (zero_start == '0) ? now_reg : zero_start;
        end
        else if (do_hit)
        begin
            wr_count = inc_res;
            wr_start = rd_start;
        end
        else
        begin
            wr_count = DATA_W'(1);
            wr_start = now_reg;
        end
    end

    assign fin_idx     = do_hit ? ptr_reg : (do_miss ? fill_reg[IDX_W-1:0] : '0);
    assign fin_idx_ext = {{SLOT_W{1'b0}}, fin_idx};
    assign wr_addr     = fin_idx;

    assign tbl_ctl.id_we   = do_miss;
    assign tbl_ctl.data_we = do_hit || do_miss;
    assign tbl_ctl.zero_we = do_zero;

    pscet_table #(
        .SLOTS (SLOTS)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tbl_ctl),
        .rd_addr    (ptr_next),
        .wr_addr    (wr_addr),
        .wr_id      (id_reg),
        .wr_count   (wr_count),
        .wr_start   (wr_start),
        .wr_end     (now_reg),
        .rd_id      (rd_id),
        .rd_count   (rd_count),
        .rd_start   (rd_start),
        .rd_end     (rd_end),
        .zero_count (zero_count),
        .zero_start (zero_start),
        .zero_end   (zero_end)
    );

    // Result register.
    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        slot_next      = slot_reg;
        count_next     = count_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        new_next       = new_reg;
        notify_next    = notify_reg;
        ovf_next       = ovf_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
            slot_next      = fin_idx_ext[SLOT_W-1:0];
            count_next     = wr_count;
            first_next     = wr_start;
            last_next      = now_reg;
            new_next       = do_miss;
            notify_next    = do_miss && notify_en_reg;
            ovf_next       = do_zero && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        count_reg  <= count_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        new_reg    <= new_next;
        notify_reg <= notify_next;
        ovf_reg    <= ovf_next;
    end

    assign res_valid   = res_valid_reg;
    assign slot        = slot_reg;
    assign event_count = count_reg;
    assign first_seen  = first_reg;
    assign last_seen   = last_reg;
    assign new_entry   = new_reg;
    assign notify      = notify_reg;
    assign overflowed  = ovf_reg;

    // The end time of the reserved slot is kept for completeness; the stored
    // end time of a searched slot is always overwritten by the event time.
    logic unused_ends;
    assign unused_ends = ^{zero_end, rd_end};

    // The search pointer lies above the reserved slot and below the fill count.
    logic search_ptr_ok;
    assign search_ptr_ok = (FILL_W'(ptr_reg) < fill_reg) && (ptr_reg != '0);

    // The fill count stays between one and the number of slots.
    `ASSERT_ALWAYS(a_fill_range, clk, rst_n, fill_reg != '0 && fill_reg <= FILL_W'(SLOTS))
    // The search pointer only ever addresses occupied slots above the reserved one.
    `ASSERT_IMPLIES(a_ptr_in_fill, clk, rst_n, state_reg == ST_SEARCH, search_ptr_ok)
    // No slot is appended while the sequencer is idle.
    `ASSERT_NEXT(a_idle_keeps_fill, clk, rst_n, state_reg == ST_IDLE, fill_reg == $past(fill_reg))
    // A result only appears after an event has been worked on.
    `ASSERT_IMPLIES(a_res_from_work, clk, rst_n, $rose(res_valid_reg), $past(state_reg) != ST_IDLE)

endmodule
